// ----- sv/lfu_slot_replacement_macros.svh -----
// Assertion macros shared by the LFU slot replacement block.
`ifndef LFU_SLOT_REPLACEMENT_MACROS_SVH
`define LFU_SLOT_REPLACEMENT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LFU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LFU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lfu_pkg.sv -----
// Shared types, constants and helper functions of the LFU slot replacement block.
package lfu_pkg;

  localparam int SLOTS   = 16;
  localparam int ID_BITS = 8;
  localparam int CFG_W   = 5;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int CTR_W   = 32;

  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [SLOT_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [CTR_W-1:0]   ctr_t;

  // One slot of the table as it sits in memory.
  typedef struct packed {
    id_t  owner;
    ctr_t uses;
    ctr_t ins;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE
  } state_e;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic clear;
    logic vld;
    idx_t idx;
    id_t  id;
  } scan_ctl_t;

  // Findings of one scan over the active slots.
  typedef struct packed {
    logic hit;
    idx_t hit_idx;
    ctr_t hit_uses;
    ctr_t hit_ins;
    logic empty;
    idx_t empty_idx;
    idx_t vic_idx;
    id_t  vic_owner;
  } scan_res_t;

  // Counter increment that sticks at all ones.
  function automatic ctr_t sat_inc(input ctr_t v);
    return (v == '1) ? v : v + ctr_t'(1);
  endfunction

  // Number of active slots: zero acts as one, too large acts as SLOTS.
  function automatic cnt_t active_count(input logic [CFG_W-1:0] cfg);
    cnt_t n;
    if (cfg == '0) begin
      n = cnt_t'(1);
    end else if (32'(cfg) > SLOTS) begin
      n = cnt_t'(SLOTS);
    end else begin
      n = cnt_t'(cfg);
    end
    return n;
  endfunction

endpackage

// ----- sv/lfu_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/lfu_scan.sv -----
// Scan unit: tracks first hit, first empty slot and least-used oldest victim.
module lfu_scan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lfu_pkg::scan_ctl_t ctl_i,
  input  lfu_pkg::entry_t    entry_i,
  output lfu_pkg::scan_res_t res_o
);

  lfu_pkg::scan_res_t res_q, res_d;
  logic               vic_found_q, vic_found_d;
  lfu_pkg::ctr_t      vic_uses_q, vic_uses_d;
  lfu_pkg::ctr_t      vic_ins_q, vic_ins_d;
  logic               better;

  // A slot beats the current victim on fewer uses, then on older insertion.
  assign better = (entry_i.uses < vic_uses_q) ||
                  ((entry_i.uses == vic_uses_q) && (entry_i.ins < vic_ins_q));

  // Fold one slot beat into the running findings.
  always_comb begin
    res_d       = res_q;
    vic_found_d = vic_found_q;
    vic_uses_d  = vic_uses_q;
    vic_ins_d   = vic_ins_q;
    if (ctl_i.clear) begin
      res_d.hit   = 1'b0;
      res_d.empty = 1'b0;
      vic_found_d = 1'b0;
    end else if (ctl_i.vld) begin
      if (!res_q.hit && (entry_i.owner == ctl_i.id)) begin
        res_d.hit      = 1'b1;
        res_d.hit_idx  = ctl_i.idx;
        res_d.hit_uses = entry_i.uses;
        res_d.hit_ins  = entry_i.ins;
      end
      if (!res_q.empty && (entry_i.owner == '0)) begin
        res_d.empty     = 1'b1;
        res_d.empty_idx = ctl_i.idx;
      end
      if (!vic_found_q || better) begin
        vic_found_d     = 1'b1;
        vic_uses_d      = entry_i.uses;
        vic_ins_d       = entry_i.ins;
        res_d.vic_idx   = ctl_i.idx;
        res_d.vic_owner = entry_i.owner;
      end
    end
  end

  // Findings and the running victim, all in one register bank.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q       <= '0;
      vic_found_q <= 1'b0;
      vic_uses_q  <= '0;
      vic_ins_q   <= '0;
    end else begin
      res_q       <= res_d;
      vic_found_q <= vic_found_d;
      vic_uses_q  <= vic_uses_d;
      vic_ins_q   <= vic_ins_d;
    end
  end

  assign res_o = res_q;

endmodule

// ----- sv/lfu_ctrl.sv -----
// Sequencer: request intake, slot sweep, table write-back and result register.
module lfu_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [7:0]                 candidate_id_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [lfu_pkg::CFG_W-1:0]  cfg_slots_in_use_i,
  output logic                       ram_we_o,
  output lfu_pkg::idx_t              ram_waddr_o,
  output lfu_pkg::entry_t            ram_wdata_o,
  output logic                       ram_re_o,
  output lfu_pkg::idx_t              ram_raddr_o,
  input  lfu_pkg::entry_t            ram_rdata_i,
  output lfu_pkg::scan_ctl_t         scan_ctl_o,
  output lfu_pkg::entry_t            scan_entry_o,
  input  lfu_pkg::scan_res_t         scan_res_i,
  output logic                       valid_o,
  output logic                       hit_o,
  output logic [3:0]                 slot_index_o,
  output logic                       evicted_o,
  output logic [7:0]                 evicted_id_o
);

  lfu_pkg::state_e            state_q, state_d;
  logic [lfu_pkg::CFG_W-1:0]  cfg_q;
  lfu_pkg::idx_t              addr_q, addr_d;
  lfu_pkg::idx_t              ridx_q;
  logic                       rvld_q, rvld_d;
  lfu_pkg::id_t               id_q, id_d;
  lfu_pkg::ctr_t              ctr_q, ctr_d;
  logic [lfu_pkg::SLOTS-1:0]  slot_vld_q, slot_vld_d;
  lfu_pkg::cnt_t              n_act;
  lfu_pkg::id_t               in_id;
  logic                       accept;
  logic                       last_addr;
  logic                       valid_d, hit_d, ev_d;
  lfu_pkg::idx_t              tgt_d, tgt_q;
  lfu_pkg::id_t               evid_d, evid_q;
  logic                       hit_q, ev_q, valid_q;

  assign n_act     = lfu_pkg::active_count(cfg_q);
  assign in_id     = lfu_pkg::id_t'(candidate_id_i);
  assign busy      = (state_q != lfu_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign last_addr = ((lfu_pkg::cnt_t'(addr_q) + lfu_pkg::cnt_t'(1)) == n_act);
  // The slot count is only taken while no sweep is running.
  assign cfg_ready_o = !busy;

  // Slots never written since reset read as empty.
  assign scan_entry_o = slot_vld_q[ridx_q] ? ram_rdata_i : '0;
  assign scan_ctl_o.clear = accept && (in_id != '0);
  assign scan_ctl_o.vld   = rvld_q;
  assign scan_ctl_o.idx   = ridx_q;
  assign scan_ctl_o.id    = id_q;

  // Next state, memory accesses and result selection.
  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    rvld_d      = 1'b0;
    id_d        = id_q;
    ctr_d       = ctr_q;
    slot_vld_d  = slot_vld_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = addr_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = scan_res_i.vic_idx;
    ram_wdata_o = '0;
    valid_d     = 1'b0;
    hit_d       = 1'b0;
    ev_d        = 1'b0;
    tgt_d       = '0;
    evid_d      = '0;
    case (state_q)
      lfu_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_id == '0) begin
            // Reserved id: answer at once with an all-zero result.
            valid_d = 1'b1;
          end else begin
            id_d    = in_id;
            addr_d  = '0;
            state_d = lfu_pkg::ST_SCAN;
          end
        end
      end
      lfu_pkg::ST_SCAN: begin
        ram_re_o = 1'b1;
        rvld_d   = 1'b1;
        addr_d   = addr_q + lfu_pkg::idx_t'(1);
        if (last_addr) begin
          state_d = lfu_pkg::ST_DRAIN;
        end
      end
      lfu_pkg::ST_DRAIN: begin
        state_d = lfu_pkg::ST_WRITE;
      end
      lfu_pkg::ST_WRITE: begin
        ram_we_o = 1'b1;
        valid_d  = 1'b1;
        if (scan_res_i.hit) begin
          hit_d             = 1'b1;
          tgt_d             = scan_res_i.hit_idx;
          ram_wdata_o.owner = id_q;
          ram_wdata_o.uses  = lfu_pkg::sat_inc(scan_res_i.hit_uses);
          ram_wdata_o.ins   = scan_res_i.hit_ins;
        end else begin
          if (scan_res_i.empty) begin
            tgt_d = scan_res_i.empty_idx;
          end else begin
            tgt_d  = scan_res_i.vic_idx;
            ev_d   = 1'b1;
            evid_d = scan_res_i.vic_owner;
          end
          ram_wdata_o.owner = id_q;
          ram_wdata_o.uses  = lfu_pkg::ctr_t'(1);
          ram_wdata_o.ins   = ctr_q;
        end
        ram_waddr_o       = tgt_d;
        slot_vld_d[tgt_d] = 1'b1;
        ctr_d             = lfu_pkg::sat_inc(ctr_q);
        state_d           = lfu_pkg::ST_IDLE;
      end
      default: begin
        state_d = lfu_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lfu_pkg::ST_IDLE;
      cfg_q      <= lfu_pkg::CFG_W'(16);
      rvld_q     <= 1'b0;
      ctr_q      <= '0;
      slot_vld_q <= '0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      rvld_q     <= rvld_d;
      ctr_q      <= ctr_d;
      slot_vld_q <= slot_vld_d;
      valid_q    <= valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_slots_in_use_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    ridx_q <= addr_q;
    id_q   <= id_d;
    hit_q  <= hit_d;
    ev_q   <= ev_d;
    tgt_q  <= tgt_d;
    evid_q <= evid_d;
  end

  assign valid_o      = valid_q;
  assign hit_o        = hit_q;
  assign slot_index_o = 4'(tgt_q);
  assign evicted_o    = ev_q;
  assign evicted_id_o = 8'(evid_q);

endmodule

// ----- sv/lfu_slot_replacement.sv -----
// A nonzero id keeps busy high while it sweeps the n active slots, drains and writes back.
// The result strobe rises as busy falls; an id of zero answers in the next cycle.
// A new request is taken only once busy falls; the memory sweep reads one slot per cycle.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset: all slots read empty through per-slot valid flags, no clearing pass; n is 16.
`include "lfu_slot_replacement_macros.svh"

module lfu_slot_replacement (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] candidate_id_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [4:0] cfg_slots_in_use_i,
  output logic       valid_o,
  output logic       hit_o,
  output logic [3:0] slot_index_o,
  output logic       evicted_o,
  output logic [7:0] evicted_id_o
);

  logic               ram_we;
  lfu_pkg::idx_t      ram_waddr;
  lfu_pkg::entry_t    ram_wdata;
  logic               ram_re;
  lfu_pkg::idx_t      ram_raddr;
  lfu_pkg::entry_t    ram_rdata;
  lfu_pkg::scan_ctl_t scan_ctl;
  lfu_pkg::entry_t    scan_entry;
  lfu_pkg::scan_res_t scan_res;

  // Slot table: owner, use count and insertion time per slot.
  lfu_ram #(
    .WIDTH (lfu_pkg::ENTRY_W),
    .DEPTH (lfu_pkg::SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer and result register.
  lfu_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .candidate_id_i     (candidate_id_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_slots_in_use_i (cfg_slots_in_use_i),
    .ram_we_o           (ram_we),
    .ram_waddr_o        (ram_waddr),
    .ram_wdata_o        (ram_wdata),
    .ram_re_o           (ram_re),
    .ram_raddr_o        (ram_raddr),
    .ram_rdata_i        (ram_rdata),
    .scan_ctl_o         (scan_ctl),
    .scan_entry_o       (scan_entry),
    .scan_res_i         (scan_res),
    .valid_o            (valid_o),
    .hit_o              (hit_o),
    .slot_index_o       (slot_index_o),
    .evicted_o          (evicted_o),
    .evicted_id_o       (evicted_id_o)
  );

  // Hit, empty and victim search over the swept slots.
  lfu_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (scan_ctl),
    .entry_i (scan_entry),
    .res_o   (scan_res)
  );

  // A result beat only appears as the block frees up.
  `LFU_ASSERT_NOW(a_valid_not_busy, valid_o, !busy, "result beat while busy")

  // A hit never evicts.
  `LFU_ASSERT_NOW(a_hit_no_evict, valid_o && hit_o, !evicted_o, "hit with eviction")

  // The reserved id answers next cycle with an all-zero result.
  `LFU_ASSERT_NEXT(a_zero_id, start && !busy && (candidate_id_i == 8'd0),
                   valid_o && !hit_o && !evicted_o && (evicted_id_o == 8'd0),
                   "reserved id result wrong")

  // A real request starts a sweep and shows no result yet.
  `LFU_ASSERT_NEXT(a_sweep_start, start && !busy && (candidate_id_i != 8'd0),
                   busy && !valid_o, "request did not start a sweep")

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the LFU slot replacement block.
`timescale 1ns / 100ps

module tb;

  // One result beat as the block presents it.
  typedef struct packed {
    logic       hit;
    logic [3:0] slot;
    logic       evicted;
    logic [7:0] victim_id;
  } lookup_t;

  // One row of the directed table; pinned rows carry a hand-written expectation.
  typedef struct packed {
    logic          pinned;
    lfu_pkg::id_t  id;
    lookup_t       want;
  } dir_row_t;

  localparam int DIR_N      = 24;
  localparam int PHASE_ITEMS = 148;
  localparam int PLAN_N     = 9;

  localparam lookup_t NO_RESULT = '{1'b0, 4'd0, 1'b0, 8'd0};

  // Directed requests right after reset with all sixteen slots active.
  localparam dir_row_t DIR_TBL [DIR_N] = '{
    '{1'b1, 8'h00, NO_RESULT},                  // reserved id on an empty table
    '{1'b1, 8'h01, '{1'b0, 4'd0, 1'b0, 8'd0}},  // lowest id fills slot 0
    '{1'b1, 8'hFF, '{1'b0, 4'd1, 1'b0, 8'd0}},  // highest id fills slot 1
    '{1'b1, 8'h01, '{1'b1, 4'd0, 1'b0, 8'd0}},  // hit on slot 0
    '{1'b1, 8'h80, '{1'b0, 4'd2, 1'b0, 8'd0}},
    '{1'b1, 8'h7F, '{1'b0, 4'd3, 1'b0, 8'd0}},
    '{1'b1, 8'h55, '{1'b0, 4'd4, 1'b0, 8'd0}},
    '{1'b1, 8'hAA, '{1'b0, 4'd5, 1'b0, 8'd0}},
    '{1'b1, 8'h00, NO_RESULT},                  // reserved id leaves the table alone
    '{1'b1, 8'hFF, '{1'b1, 4'd1, 1'b0, 8'd0}},  // hit on slot 1
    '{1'b0, 8'h02, NO_RESULT},
    '{1'b0, 8'h03, NO_RESULT},
    '{1'b0, 8'h04, NO_RESULT},
    '{1'b0, 8'h05, NO_RESULT},
    '{1'b0, 8'h06, NO_RESULT},
    '{1'b0, 8'h07, NO_RESULT},
    '{1'b0, 8'h08, NO_RESULT},
    '{1'b0, 8'h09, NO_RESULT},
    '{1'b0, 8'h0A, NO_RESULT},
    '{1'b0, 8'h0B, NO_RESULT},                  // table is now full
    '{1'b0, 8'h0C, NO_RESULT},                  // first eviction
    '{1'b0, 8'h0D, NO_RESULT},
    '{1'b0, 8'h0C, NO_RESULT},
    '{1'b0, 8'h01, NO_RESULT}
  };

  // Slot counts for the random phases: shrink to one, zero, oversize, then mixed.
  localparam logic [4:0] SLOT_PLAN [PLAN_N] = '{
    5'd1, 5'd0, 5'd31, 5'd17, 5'd3, 5'd8, 5'd2, 5'd12, 5'd16
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [7:0] candidate_id_i = 8'd0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [4:0] cfg_slots_in_use_i = 5'd16;
  logic       valid_o;
  logic       hit_o;
  logic [3:0] slot_index_o;
  logic       evicted_o;
  logic [7:0] evicted_id_o;

  // Predicted table contents and the active-slot register.
  lfu_pkg::id_t  owner_tbl [lfu_pkg::SLOTS];
  lfu_pkg::ctr_t uses_tbl  [lfu_pkg::SLOTS];
  lfu_pkg::ctr_t born_tbl  [lfu_pkg::SLOTS];
  lfu_pkg::ctr_t req_count;
  logic [4:0]    cfg_word;

  lookup_t    expect_q [$];
  logic       pin_valid = 1'b0;
  lookup_t    pin_result = NO_RESULT;

  int fail_count;
  int sent_count;
  int hit_total;
  int evict_total;
  int zero_total;
  int cfg_total;
  int burst_left;
  lfu_pkg::id_t pool [24];

  lfu_slot_replacement dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .candidate_id_i     (candidate_id_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_slots_in_use_i (cfg_slots_in_use_i),
    .valid_o            (valid_o),
    .hit_o              (hit_o),
    .slot_index_o       (slot_index_o),
    .evicted_o          (evicted_o),
    .evicted_id_o       (evicted_id_o)
  );

  always #10 clk_i = ~clk_i;

  // Counters stick at all ones.
  function automatic lfu_pkg::ctr_t sat_bump(input lfu_pkg::ctr_t v);
    return (v == '1) ? v : v + lfu_pkg::ctr_t'(1);
  endfunction

  // Slots actually searched: zero means one, anything past the table means all.
  function automatic int live_slots(input logic [4:0] v);
    int n;
    n = int'(v);
    if (n == 0) n = 1;
    if (n > lfu_pkg::SLOTS) n = lfu_pkg::SLOTS;
    return n;
  endfunction

  // Applies one request to the predicted table and returns the beat it should produce.
  function automatic lookup_t predict_lookup(input lfu_pkg::id_t id);
    lookup_t r;
    int      n;
    int      tgt;
    bit      found;
    r = NO_RESULT;
    if (id == '0) begin
      zero_total++;
      return r;
    end
    n = live_slots(cfg_word);
    tgt = 0;
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!found && owner_tbl[i] == id) begin
        tgt = i;
        found = 1'b1;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      uses_tbl[tgt] = sat_bump(uses_tbl[tgt]);
      hit_total++;
    end else begin
      for (int i = 0; i < n; i++) begin
        if (!found && owner_tbl[i] == '0) begin
          tgt = i;
          found = 1'b1;
        end
      end
      // No free slot: the least used goes, the oldest insertion breaks ties.
      if (!found) begin
        tgt = 0;
        for (int i = 1; i < n; i++) begin
          if (uses_tbl[i] < uses_tbl[tgt] ||
              (uses_tbl[i] == uses_tbl[tgt] && born_tbl[i] < born_tbl[tgt])) begin
            tgt = i;
          end
        end
        r.evicted = 1'b1;
        r.victim_id = owner_tbl[tgt];
        evict_total++;
      end
      owner_tbl[tgt] = id;
      uses_tbl[tgt] = lfu_pkg::ctr_t'(1);
      born_tbl[tgt] = req_count;
    end
    req_count = sat_bump(req_count);
    r.slot = tgt[3:0];
    return r;
  endfunction

  task automatic flag_field(input string name, input int want, input int got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("tb: %s mismatch at %0t: expected 0x%0h, got 0x%0h", name, $realtime, want,
               got);
    end
  endtask

  // Watches both handshakes, keeps the predicted table in step and checks every result beat.
  always @(posedge clk_i) begin : watch
    lookup_t got;
    lookup_t want;
    if (rst_ni) begin
      if (valid_o) begin
        got = '{hit_o, slot_index_o, evicted_o, evicted_id_o};
        if (expect_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("tb: unexpected result beat at %0t", $realtime);
        end else begin
          want = expect_q.pop_front();
          if (got.hit !== want.hit) flag_field("hit", want.hit, got.hit);
          if (got.slot !== want.slot) flag_field("slot_index", want.slot, got.slot);
          if (got.evicted !== want.evicted) flag_field("evicted", want.evicted, got.evicted);
          if (got.victim_id !== want.victim_id) begin
            flag_field("evicted_id", want.victim_id, got.victim_id);
          end
        end
      end
      if (start && !busy) begin
        want = predict_lookup(candidate_id_i);
        if (pin_valid) want = pin_result;
        expect_q.push_back(want);
      end
      if (cfg_valid_i && cfg_ready_o) cfg_word = cfg_slots_in_use_i;
    end
  end

  // Offers one request and returns at the edge that accepts it.
  task automatic send_request(input lfu_pkg::id_t id, input logic pinned, input lookup_t want);
    start <= 1'b1;
    candidate_id_i <= id;
    pin_valid <= pinned;
    pin_result <= want;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent_count++;
  endtask

  // Sender bursts: keep start up inside a burst, drop it for a random gap between bursts.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      candidate_id_i <= 8'($urandom);
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // Lets every outstanding request finish so the register can be written safely.
  task automatic drain();
    start <= 1'b0;
    while (expect_q.size() != 0) @(posedge clk_i);
    repeat (lfu_pkg::SLOTS + 4) @(posedge clk_i);
  endtask

  task automatic write_slots(input logic [4:0] v);
    cfg_valid_i <= 1'b1;
    cfg_slots_in_use_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_total++;
  endtask

  // Mostly ids from a working set a little larger than the active slots, so hits and
  // evictions both happen; the rest is any id, with the reserved id now and then.
  function automatic lfu_pkg::id_t pick_id();
    int r;
    int span;
    r = $urandom_range(0, 99);
    span = live_slots(cfg_word) + 2;
    if (span > 23) span = 23;
    if (r < 3) return '0;
    if (r < 75) return pool[$urandom_range(0, span)];
    return lfu_pkg::id_t'($urandom_range(1, 255));
  endfunction

  // Stimulus: reset, directed table, then random phases over several slot counts.
  initial begin
    for (int i = 0; i < lfu_pkg::SLOTS; i++) begin
      owner_tbl[i] = '0;
      uses_tbl[i] = '0;
      born_tbl[i] = '0;
    end
    req_count = '0;
    cfg_word = 5'd16;
    fail_count = 0;
    sent_count = 0;
    hit_total = 0;
    evict_total = 0;
    zero_total = 0;
    cfg_total = 0;
    burst_left = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_slots(5'd16);
    for (int k = 0; k < DIR_N; k++) begin
      send_request(DIR_TBL[k].id, DIR_TBL[k].pinned, DIR_TBL[k].want);
      pace();
    end

    for (int p = 0; p <= PLAN_N; p++) begin
      drain();
      write_slots((p < PLAN_N) ? SLOT_PLAN[p] : 5'($urandom));
      for (int i = 0; i < 24; i++) pool[i] = lfu_pkg::id_t'($urandom_range(1, 255));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_request(pick_id(), 1'b0, NO_RESULT);
        pace();
      end
    end

    drain();
    if (expect_q.size() != 0) fail_count++;
    $display("tb: %0d requests over %0d slot-count settings", sent_count, cfg_total);
    $display("tb: %0d hits, %0d evictions, %0d reserved-id requests, %0d failures",
             hit_total, evict_total, zero_total, fail_count);
    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("tb: timeout with %0d results outstanding", expect_q.size());
    $display("tb: done, errors");
    $finish;
  end

endmodule
